// ===== sv/hcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcs_pkg: shared constants for the Hamiltonian cycle search core
// Sizes of the row store, path stack, vertex indexes and counters.
// ----------------------------------------------------------------------------
package hcs_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int CFG_W        = 5;
    localparam int VTX_W        = 4;

    localparam logic [CFG_W-1:0] COUNT_RESET = CFG_W'(5);
    localparam logic [CNT_W-1:0] COUNT_MIN   = CNT_W'(2);
    localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(MAX_VERTICES);

    typedef logic [MAX_VERTICES-1:0] row_t;
    typedef logic [IDX_W-1:0]        vidx_t;
    typedef logic [CNT_W-1:0]        cnt_t;

endpackage

`default_nettype wire

// ===== sv/hamiltonian_cycle_search_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hamiltonian_cycle_search_core: backtracking Hamiltonian cycle search
// Loads adjacency rows, searches depth first from vertex 0, emits the cycle or a not-found word.
// ----------------------------------------------------------------------------
// Usage: write vertex_count (clamped to 2..16) while the core is idle, then
// send one adjacency row per word, row 0 first. The word carrying row
// vertex_count-1 starts the search, during which in_stall stays high;
// in_stall is also high in any cycle with cfg_wr_en high. The search
// sequencer tests one candidate, one push, or one pop per cycle against the
// row of the current path top, so the search time grows with the number of
// candidates tried and backtracks; worst case grows with the number of
// partial paths explored. A found cycle leaves as vertex_count+1 words (path
// vertices, then vertex 0 with last set); no cycle gives one word with
// found=0 and last set. A new output word is issued whenever none is pending
// or the receiver does not stall. A pending output word does not block
// loading the next graph.
// ----------------------------------------------------------------------------
module hamiltonian_cycle_search_core (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       cfg_wr_en,
    input  wire [hcs_pkg::CFG_W-1:0]  cfg_wr_data,
    input  wire                       in_valid,
    output logic                      in_stall,
    input  wire [hcs_pkg::MAX_VERTICES-1:0] row_bits,
    output logic                      out_valid,
    input  wire                       out_stall,
    output logic                      found,
    output logic [hcs_pkg::VTX_W-1:0] vertex,
    output logic                      last
);
    import hcs_pkg::*;

    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    row_t  adj_mem  [MAX_VERTICES];
    vidx_t path_mem [MAX_VERTICES];

    logic [1:0]       state_reg, state_next;
    logic [CFG_W-1:0] count_reg, count_next;
    cnt_t             rows_reg, rows_next;
    cnt_t             depth_reg, depth_next;
    cnt_t             cand_reg, cand_next;
    row_t             visited_reg, visited_next;
    vidx_t            top_reg, top_next;
    logic             hit_reg, hit_next;
    cnt_t             idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic             found_reg, found_next;
    logic [VTX_W-1:0] vertex_reg, vertex_next;
    logic             last_reg, last_next;
    row_t             top_row_reg;
    vidx_t            path_rd_reg;

    cnt_t  n_eff;
    cnt_t  rows_eff;
    cnt_t  depth_m2;
    vidx_t path_rd_addr;
    logic  adj_we;
    vidx_t adj_waddr;
    logic  path_we;
    vidx_t path_waddr;
    vidx_t path_wdata;
    logic  in_take;

    always_comb
    begin
        if (CNT_W'(count_reg) < COUNT_MIN)
            n_eff = COUNT_MIN;
        else if (CNT_W'(count_reg) > COUNT_MAX)
            n_eff = COUNT_MAX;
        else
            n_eff = CNT_W'(count_reg);
    end

    assign in_stall     = (state_reg != ST_LOAD) || cfg_wr_en;
    assign in_take      = in_valid && !in_stall;
    assign rows_eff     = (rows_reg >= n_eff) ? '0 : rows_reg;
    assign depth_m2     = depth_next - CNT_W'(2);
    assign path_rd_addr = (state_next == ST_EMIT) ? idx_next[IDX_W-1:0]
                                                  : depth_m2[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rows_next      = rows_reg;
        depth_next     = depth_reg;
        cand_next      = cand_reg;
        visited_next   = visited_reg;
        top_next       = top_reg;
        hit_next       = hit_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        vertex_next    = vertex_reg;
        last_next      = last_reg;
        adj_we         = 1'b0;
        adj_waddr      = rows_eff[IDX_W-1:0];
        path_we        = 1'b0;
        path_waddr     = depth_reg[IDX_W-1:0];
        path_wdata     = cand_reg[IDX_W-1:0];

        // drop the output word once taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                if (cfg_wr_en)
                begin
                    count_next = cfg_wr_data;
                    rows_next  = '0;
                end
                else if (in_take)
                begin
                    adj_we = 1'b1;
                    if (rows_eff + CNT_W'(1) < n_eff)
                        rows_next = rows_eff + CNT_W'(1);
                    else
                    begin
                        rows_next    = '0;
                        path_we      = 1'b1;
                        path_waddr   = '0;
                        path_wdata   = '0;
                        visited_next = row_t'(1);
                        depth_next   = CNT_W'(1);
                        cand_next    = CNT_W'(1);
                        top_next     = '0;
                        state_next   = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (depth_reg < n_eff && cand_reg < n_eff)
                begin
                    // test one candidate
                    if (top_row_reg[cand_reg[IDX_W-1:0]] &&
                        !visited_reg[cand_reg[IDX_W-1:0]])
                    begin
                        path_we      = 1'b1;
                        visited_next = visited_reg | (row_t'(1) << cand_reg[IDX_W-1:0]);
                        depth_next   = depth_reg + CNT_W'(1);
                        top_next     = cand_reg[IDX_W-1:0];
                        cand_next    = CNT_W'(1);
                    end
                    else
                        cand_next = cand_reg + CNT_W'(1);
                end
                else if (depth_reg >= n_eff && top_row_reg[0])
                begin
                    hit_next   = 1'b1;
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
                else if (depth_reg <= CNT_W'(1))
                begin
                    hit_next   = 1'b0;
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    // backtrack: pop the top vertex
                    depth_next   = depth_reg - CNT_W'(1);
                    visited_next = visited_reg & ~(row_t'(1) << top_reg);
                    cand_next    = CNT_W'(top_reg) + CNT_W'(1);
                    top_next     = path_rd_reg;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    found_next     = hit_reg;
                    vertex_next    = (hit_reg && idx_reg < n_eff) ? VTX_W'(path_rd_reg) : '0;
                    last_next      = !hit_reg || (idx_reg == n_eff);
                    idx_next       = idx_reg + CNT_W'(1);
                    if (!hit_reg || idx_reg == n_eff)
                        state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= COUNT_RESET;
            rows_reg      <= '0;
            depth_reg     <= '0;
            cand_reg      <= '0;
            visited_reg   <= '0;
            top_reg       <= '0;
            hit_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rows_reg      <= rows_next;
            depth_reg     <= depth_next;
            cand_reg      <= cand_next;
            visited_reg   <= visited_next;
            top_reg       <= top_next;
            hit_reg       <= hit_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg   <= found_next;
        vertex_reg  <= vertex_next;
        last_reg    <= last_next;
        top_row_reg <= adj_mem[top_next];
        path_rd_reg <= path_mem[path_rd_addr];
        if (adj_we)
            adj_mem[adj_waddr] <= row_bits;
        if (path_we)
            path_mem[path_waddr] <= path_wdata;
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign vertex    = vertex_reg;
    assign last      = last_reg;

    a_start_visited: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> visited_reg[0])
        else $error("vertex 0 not marked during search");

    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (depth_reg >= CNT_W'(1) && depth_reg <= n_eff))
        else $error("search depth out of range");

    a_mask_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> ($countones(visited_reg) == int'(depth_reg)))
        else $error("visited mask disagrees with search depth");

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |=> in_stall || (out_valid_reg && last_reg))
        else $error("input opened before last word issued");

endmodule

`default_nettype wire
